@@ rtl/rfd_pkg.sv @@
package rfd_pkg;

    localparam int DEF_MAX_TERMS = 8;
    localparam int DEF_FRAC_BITS = 16;
    localparam int CFG_REGS      = 4;
    localparam int CFG_AW        = 4;

    // input commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEN0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FIELD_NUM = 2'd0;
    localparam logic [1:0] REG_FIELD_DEN = 2'd1;
    localparam logic [1:0] REG_PHASE_NUM = 2'd2;
    localparam logic [1:0] REG_PHASE_DEN = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HORNER,
        S_QUOT,
        S_D1,
        S_D2,
        S_DONE
    } rfd_state_t;

    typedef enum logic [1:0] {
        DIV_QUOT,
        DIV_D1,
        DIV_D2
    } rfd_div_sel_t;

    // saturate a 64-bit value to 32 bits
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sh0000_0000_8000_0000)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // round to nearest (ties up) dropping fb bits, then saturate
    function automatic logic [32:0] rnd_sat(input logic signed [63:0] p, input int fb);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (fb - 1))) >>> fb;
        return sat32(t);
    endfunction

endpackage

@@ rtl/rfd_if.sv @@
interface rfd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        which_function;
    logic        which_part;
    logic [2:0]  term_index;
    logic signed [31:0] data_value;
    modport source (output valid, cmd, which_function, which_part, term_index, data_value,
                    input ready);
    modport sink   (input valid, cmd, which_function, which_part, term_index, data_value,
                    output ready);
endinterface

interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] quotient;
    logic signed [31:0] first_derivative;
    logic signed [31:0] second_derivative;
    logic [1:0]  status;
    modport source (output valid, quotient, first_derivative, second_derivative, status,
                    input ready);
    modport sink   (input valid, quotient, first_derivative, second_derivative, status,
                    output ready);
endinterface

@@ rtl/rfd_cell.sv @@
// One Horner cell: holds the coefficient of one power of x for every polynomial,
// and in each step takes the accumulators of its upper neighbor, multiplies by x,
// adds its scaled coefficient and hands the result down.
module rfd_cell
    import rfd_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int IDX       = 0
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        wr_poly,
    input  logic signed [31:0] wr_data,
    input  logic              step,        // this cell's turn in the chain
    input  logic              start,       // cell begins a fresh chain
    input  logic [1:0]        num_poly,
    input  logic [1:0]        den_poly,
    input  logic              num_act,     // index below numerator term count
    input  logic              den_act,
    input  logic signed [31:0] x,
    input  logic signed [31:0] acc_in [6],
    input  logic              sat_in,
    output logic signed [31:0] acc_out [6],
    output logic              sat_out
);
    logic signed [31:0] coef_reg [4];
    logic signed [31:0] acc_reg [6];
    logic signed [31:0] acc_next [6];
    logic               sat_reg, sat_next;
    logic signed [31:0] c0 [6];
    logic               c0s [6];
    logic [32:0]        m, s, f1, f2;
    logic signed [63:0] k1, k2;
    logic signed [31:0] cn, cd;
    logic               act [6];

    // coefficient storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < 4; p++)
                coef_reg[p] <= (IDX == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
        end
        else if (wr_en)
        begin
            coef_reg[wr_poly] <= wr_data;
        end
    end

    assign cn = coef_reg[num_poly];
    assign cd = coef_reg[den_poly];
    assign k1 = 64'(IDX);
    assign k2 = 64'(IDX * (IDX - 1));

    // scaled coefficients: order 0,1,2 for numerator then denominator
    always_comb
    begin
        f1 = sat32(64'(cn) * k1);
        f2 = sat32(64'(cn) * k2);
        c0[0] = cn;        c0s[0] = 1'b0;
        c0[1] = f1[31:0];  c0s[1] = f1[32];
        c0[2] = f2[31:0];  c0s[2] = f2[32];
        f1 = sat32(64'(cd) * k1);
        f2 = sat32(64'(cd) * k2);
        c0[3] = cd;        c0s[3] = 1'b0;
        c0[4] = f1[31:0];  c0s[4] = f1[32];
        c0[5] = f2[31:0];  c0s[5] = f2[32];
        act[0] = num_act;
        act[1] = num_act && (IDX >= 1);
        act[2] = num_act && (IDX >= 2);
        act[3] = den_act;
        act[4] = den_act && (IDX >= 1);
        act[5] = den_act && (IDX >= 2);
    end

    // Horner step per lane
    always_comb
    begin
        sat_next = sat_in;
        for (int l = 0; l < 6; l++)
        begin
            logic signed [31:0] a;
            a = start ? 32'sd0 : acc_in[l];
            m = rnd_sat(64'(a) * 64'(x), FRAC_BITS);
            s = sat32(64'(signed'(m[31:0])) + 64'(c0[l]));
            if (act[l])
            begin
                acc_next[l] = s[31:0];
                sat_next = sat_next | m[32] | s[32] | c0s[l];
            end
            else
            begin
                acc_next[l] = a;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else if (step)
            sat_reg <= sat_next;
    end

    assign acc_out = acc_reg;
    assign sat_out = sat_reg;
endmodule

@@ rtl/rfd_div.sv @@
// Restoring divider: num * 2^F / d, truncated toward zero, saturated to 32 bits.
module rfd_div
    import rfd_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic signed [35:0] num,
    input  logic signed [31:0] den,
    output logic              done,
    output logic signed [31:0] quo,
    output logic              sat
);
    localparam int NW = 36 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   r_reg, r_next;
    logic [31:0]   dv_reg;
    logic          neg_reg, busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] an;
    logic [33:0]   t;
    logic signed [NW:0] sq;
    logic [32:0]   sv;

    assign an = num[35] ? NW'(-(NW'(signed'(num)) <<< FRAC_BITS))
                        : NW'(NW'(num) << FRAC_BITS);

    always_comb begin
        dvd_next = dvd_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        t = '0;
        if (start) begin
            dvd_next = an;
            q_next   = '0;
            r_next   = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            t = {r_reg, dvd_reg[NW-1]} - {2'b00, dv_reg};
            if (!t[33]) begin
                r_next = t[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = {r_reg[31:0], dvd_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        if (start) begin
            dv_reg  <= den[31] ? 32'(-den) : den;
            neg_reg <= num[35] ^ den[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign sq   = neg_reg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
    assign sv   = sat32(64'(sq));
    assign quo  = sv[31:0];
    assign sat  = sv[32];
endmodule

@@ rtl/rational_function_with_derivatives.sv @@
// Channel    Role    Handshake     Payload
// item_ch    sink    valid/ready   cmd, which_function, which_part, term_index, data_value
// result_ch  source  valid/ready   quotient, first/second_derivative, status
// apb        slave   psel/penable  four 4-bit term counts at 0x0, 0x4, 0x8, 0xC
// A coefficient write is taken while idle. An evaluation runs the Horner chain, then three
// divisions on one shared divider (skipped when the denominator is zero) and a done state;
// the result turns valid and input ready returns in the same cycle, so a new item is not
// taken until the previous evaluation is through.
// Reset loads 1.0 into term 0 of every polynomial and sets all counts to 1.
// A result waits in the output register; the next one holds in done with ready low until taken.
module rational_function_with_derivatives
    import rfd_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    rfd_in_if.sink            item_ch,
    rfd_out_if.source         result_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int SW = $clog2(MAX_TERMS + 1);

    logic [3:0]  cnt_cfg_reg [CFG_REGS];
    rfd_state_t  state_reg, state_next;
    logic [SW-1:0] stp_reg, stp_next;
    logic signed [31:0] x_reg;
    logic        fn_reg;
    logic [SW-1:0] nn, dn;
    logic signed [31:0] acc [MAX_TERMS+1][6];
    logic        satc [MAX_TERMS+1];
    logic signed [31:0] quot_reg, d1_reg, d2_reg;
    logic signed [31:0] res_quot_reg, res_d1_reg, res_d2_reg;
    logic [1:0]  res_st_reg;
    logic        sat_reg, sat_next;
    logic        ovalid_reg;
    logic [1:0]  st_reg;
    logic        in_fire, wr_fire, ev_fire;
    logic        div_start;
    logic signed [35:0] div_num;
    logic        div_done, div_sat;
    logic signed [31:0] div_q;
    logic [32:0] m1, m2, m3;
    logic signed [31:0] q0, q1, q2, p1, p2;

    function automatic logic [SW-1:0] used(input logic [3:0] r);
        logic [SW-1:0] u;
        if (r == 4'd0)
            u = SW'(1);
        else if (32'(r) > MAX_TERMS)
            u = SW'(MAX_TERMS);
        else
            u = SW'(r);
        return u;
    endfunction

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
                cnt_cfg_reg[i] <= 4'd1;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            cnt_cfg_reg[paddr[3:2]] <= pwdata[3:0];
        end
    end
    assign prdata = (paddr[1:0] == 2'b00) ? {28'd0, cnt_cfg_reg[paddr[3:2]]} : 32'd0;

    assign in_fire = item_ch.valid && item_ch.ready;
    assign wr_fire = in_fire && (item_ch.cmd == CMD_WRITE);
    assign ev_fire = in_fire && (item_ch.cmd == CMD_EVAL);
    assign item_ch.ready = (state_reg == S_IDLE);

    assign nn = used(cnt_cfg_reg[{fn_reg, 1'b0}]);
    assign dn = used(cnt_cfg_reg[{fn_reg, 1'b1}]);

    // chain of cells, highest power first
    assign satc[MAX_TERMS] = 1'b0;
    for (genvar l = 0; l < 6; l++)
    begin : g_top
        assign acc[MAX_TERMS][l] = 32'sd0;
    end
    for (genvar k = 0; k < MAX_TERMS; k++)
    begin : g_cell
        logic sel;
        assign sel = (state_reg == S_HORNER) && (stp_reg == SW'(MAX_TERMS - 1 - k));
        rfd_cell #(.FRAC_BITS(FRAC_BITS), .IDX(k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .wr_en(wr_fire && (32'(item_ch.term_index) == k)),
            .wr_poly({item_ch.which_function, item_ch.which_part}),
            .wr_data(item_ch.data_value),
            .step(sel),
            .start(k == MAX_TERMS - 1),
            .num_poly({fn_reg, 1'b0}), .den_poly({fn_reg, 1'b1}),
            .num_act(SW'(k) < nn), .den_act(SW'(k) < dn),
            .x(x_reg),
            .acc_in(acc[k+1]), .sat_in(satc[k+1]),
            .acc_out(acc[k]), .sat_out(satc[k])
        );
    end

    assign q0 = acc[0][3];
    assign q1 = acc[0][4];
    assign q2 = acc[0][5];
    assign p1 = acc[0][1];
    assign p2 = acc[0][2];

    // products for the quotient-rule numerators
    assign m1 = rnd_sat(64'(quot_reg) * 64'(q1), FRAC_BITS);
    assign m2 = rnd_sat(64'(d1_reg) * 64'(q1), FRAC_BITS);
    assign m3 = rnd_sat(64'(quot_reg) * 64'(q2), FRAC_BITS);

    rfd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(q0),
        .done(div_done), .quo(div_q), .sat(div_sat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        stp_next   = stp_reg;
        div_start  = 1'b0;
        div_num    = 36'(acc[0][0]);
        sat_next   = sat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ev_fire)
                begin
                    state_next = S_HORNER;
                    stp_next   = '0;
                end
            end
            S_HORNER:
            begin
                stp_next = stp_reg + 1'b1;
                if (stp_reg == SW'(MAX_TERMS))
                begin
                    sat_next = satc[0];
                    if (q0 == 32'sd0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_QUOT;
                    end
                end
            end
            S_QUOT:
            begin
                if (div_done)
                begin
                    sat_next   = sat_reg | div_sat;
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                div_num = 36'(p1) - 36'(signed'(m1[31:0]));
                if (stp_reg != '0)
                begin
                    stp_next  = '0;
                    div_start = 1'b1;
                    sat_next  = sat_reg | m1[32];
                end
                else if (div_done)
                begin
                    sat_next   = sat_reg | div_sat;
                    state_next = S_D2;
                    stp_next   = SW'(1);
                end
            end
            S_D2:
            begin
                div_num = 36'(p2) - 36'(signed'(m2[31:0])) * 36'sd2
                        - 36'(signed'(m3[31:0]));
                if (stp_reg != '0)
                begin
                    stp_next  = '0;
                    div_start = 1'b1;
                    sat_next  = sat_reg | m2[32] | m3[32];
                end
                else if (div_done)
                begin
                    sat_next   = sat_reg | div_sat;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            stp_reg    <= '0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stp_reg   <= (state_reg == S_QUOT && div_done) ? SW'(1) : stp_next;
            sat_reg   <= sat_next;
            if (result_ch.valid && result_ch.ready)
                ovalid_reg <= 1'b0;
            else if (state_reg == S_DONE && !ovalid_reg)
                ovalid_reg <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ev_fire)
        begin
            x_reg  <= item_ch.data_value;
            fn_reg <= item_ch.which_function;
        end
        if (state_reg == S_HORNER && stp_reg == SW'(MAX_TERMS))
        begin
            quot_reg <= 32'sd0;
            d1_reg   <= 32'sd0;
            d2_reg   <= 32'sd0;
            st_reg   <= (q0 == 32'sd0) ? ST_DEN0 : ST_OK;
        end
        if (state_reg == S_QUOT && div_done)
            quot_reg <= div_q;
        if (state_reg == S_D1 && stp_reg == '0 && div_done)
            d1_reg <= div_q;
        if (state_reg == S_D2 && stp_reg == '0 && div_done)
        begin
            d2_reg <= div_q;
            st_reg <= (sat_reg | div_sat) ? ST_SAT : ST_OK;
        end
    end

    // output register, loaded as the result is raised
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && !ovalid_reg)
        begin
            res_quot_reg <= quot_reg;
            res_d1_reg   <= d1_reg;
            res_d2_reg   <= d2_reg;
            res_st_reg   <= st_reg;
        end
    end

    assign result_ch.valid             = ovalid_reg;
    assign result_ch.quotient          = res_quot_reg;
    assign result_ch.first_derivative  = res_d1_reg;
    assign result_ch.second_derivative = res_d2_reg;
    assign result_ch.status            = res_st_reg;

    // input is taken only when idle
    a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_ch.ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    // a result is raised only from the done state
    a_ov_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == S_DONE) else $error("stray result");
    // zero denominator reports zero values
    a_den0: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && res_st_reg == ST_DEN0) |-> res_quot_reg == 32'sd0 && res_d2_reg == 32'sd0)
        else $error("den0 payload");
endmodule

@@ tb/rational_function_with_derivatives_tb.sv @@
module rational_function_with_derivatives_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    localparam int NTERMS = DEF_MAX_TERMS;
    localparam int FB     = DEF_FRAC_BITS;
    localparam int SETTLE = 3 * (37 + FB) + NTERMS + 40;
    localparam logic [31:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic signed [31:0] quotient;
        logic signed [31:0] first_derivative;
        logic signed [31:0] second_derivative;
        logic [1:0]         status;
    } eval_result_t;

    typedef struct packed {
        logic               cmd;
        logic               which_function;
        logic               which_part;
        logic [2:0]         term_index;
        logic signed [31:0] data_value;
        logic               typed;
        eval_result_t       result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    rfd_in_if  in_if();
    rfd_out_if out_if();

    rational_function_with_derivatives dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (in_if),
        .result_ch (out_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow of coefficient store and term counts
    logic signed [31:0] coef_shadow [4][NTERMS];
    logic [3:0]         count_shadow [4];
    bit                 clipped;

    stim_row_t    offered_q [$];
    eval_result_t result_q [$];

    int  fail_count;
    int  eval_count, write_count, den0_count, sat_count, result_count;
    bit  long_hold;
    bit  no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    // fixed-point multiply, round half up
    function automatic int qmul(int a, int b);
        longint pr;
        pr = longint'(a) * longint'(b);
        pr = (pr + (64'sd1 <<< (FB - 1))) >>> FB;
        return clamp32(pr);
    endfunction

    function automatic int qdiv(longint num, int d);
        return clamp32((num * (64'sd1 <<< FB)) / longint'(d));
    endfunction

    function automatic int terms_in_use(logic [3:0] r);
        if (r < 1)
            return 1;
        if (r > NTERMS)
            return NTERMS;
        return int'(r);
    endfunction

    // Horner evaluation of the order-th derivative
    function automatic int horner(int poly, int n, int order, int x);
        int     acc;
        longint f;
        acc = 0;
        if (n <= order)
            return 0;
        for (int i = n - 1; i >= order; i--)
        begin
            f = 1;
            if (order >= 1) f = f * i;
            if (order >= 2) f = f * (i - 1);
            acc = clamp32(longint'(qmul(acc, x))
                          + longint'(clamp32(longint'(coef_shadow[poly][i]) * f)));
        end
        return acc;
    endfunction

    // apply one accepted item to the shadow; returns 1 with a result on evaluate
    function automatic bit apply_item(stim_row_t it, output eval_result_t r);
        int fn, nn, dn, x, p0, p1, p2, q0, q1, q2, quo, d1, d2;
        fn = int'(it.which_function);
        r = '0;
        if (it.cmd == CMD_WRITE)
        begin
            coef_shadow[fn * 2 + int'(it.which_part)][it.term_index] = it.data_value;
            return 1'b0;
        end
        clipped = 1'b0;
        x  = it.data_value;
        nn = terms_in_use(count_shadow[fn * 2]);
        dn = terms_in_use(count_shadow[fn * 2 + 1]);
        p0 = horner(fn * 2, nn, 0, x);
        p1 = horner(fn * 2, nn, 1, x);
        p2 = horner(fn * 2, nn, 2, x);
        q0 = horner(fn * 2 + 1, dn, 0, x);
        q1 = horner(fn * 2 + 1, dn, 1, x);
        q2 = horner(fn * 2 + 1, dn, 2, x);
        if (q0 == 0)
        begin
            r.status = ST_DEN0;
            return 1'b1;
        end
        quo = qdiv(longint'(p0), q0);
        d1  = qdiv(longint'(p1) - longint'(qmul(quo, q1)), q0);
        d2  = qdiv(longint'(p2) - 2 * longint'(qmul(d1, q1)) - longint'(qmul(quo, q2)), q0);
        r.quotient          = quo;
        r.first_derivative  = d1;
        r.second_derivative = d2;
        r.status            = clipped ? ST_SAT : ST_OK;
        return 1'b1;
    endfunction

    // input side: predict every accepted item
    always @(posedge clk)
    begin
        stim_row_t    it;
        eval_result_t r;
        if (rst_n && in_if.valid && in_if.ready)
        begin
            it = offered_q.pop_front();
            if (apply_item(it, r))
            begin
                eval_count++;
                result_q = {result_q, (it.typed ? it.result : r)};
            end
            else
                write_count++;
        end
    end

    // output side: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        eval_result_t e;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            result_count++;
            if (result_q.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                e = result_q.pop_front();
                if (e.status == ST_DEN0) den0_count++;
                if (e.status == ST_SAT) sat_count++;
                if (out_if.quotient !== e.quotient)
                begin
                    $error("quotient: expected %h, got %h", e.quotient, out_if.quotient);
                    fail_count++;
                end
                if (out_if.first_derivative !== e.first_derivative)
                begin
                    $error("first_derivative: expected %h, got %h",
                           e.first_derivative, out_if.first_derivative);
                    fail_count++;
                end
                if (out_if.second_derivative !== e.second_derivative)
                begin
                    $error("second_derivative: expected %h, got %h",
                           e.second_derivative, out_if.second_derivative);
                    fail_count++;
                end
                if (out_if.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, out_if.status);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int r;
        out_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (long_hold)
            begin
                out_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (no_idle || r < 65)
            begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_if.ready <= 1'b0;
                repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 80)) @(posedge clk);
            end
        end
    end

    // offer one item and hold until accepted; valid stays high
    task automatic offer_item(stim_row_t it);
        offered_q = {offered_q, it};
        in_if.valid          <= 1'b1;
        in_if.cmd            <= it.cmd;
        in_if.which_function <= it.which_function;
        in_if.which_part     <= it.which_part;
        in_if.term_index     <= it.term_index;
        in_if.data_value     <= it.data_value;
        do
            @(posedge clk);
        while (!in_if.ready);
    endtask

    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return;
        in_if.valid <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(posedge clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        wait (result_q.size() == 0 && offered_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        count_shadow[idx] = val;
    endtask

    task automatic set_counts(logic [3:0] fnum, logic [3:0] fden,
                              logic [3:0] pnum, logic [3:0] pden);
        apb_write(REG_FIELD_NUM, fnum);
        apb_write(REG_FIELD_DEN, fden);
        apb_write(REG_PHASE_NUM, pnum);
        apb_write(REG_PHASE_DEN, pden);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(bit is_write);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return $urandom();
        if (r == 2)
            return is_write ? 32'h7FFF_FFFF : 32'h8000_0000;
        // mostly modest magnitudes so results stay in range
        if (is_write)
            return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endfunction

    function automatic stim_row_t rand_item();
        stim_row_t it;
        it = '0;
        it.cmd            = ($urandom_range(0, 99) < 55) ? CMD_EVAL : CMD_WRITE;
        it.which_function = 1'($urandom_range(0, 1));
        it.which_part     = 1'($urandom_range(0, 1));
        it.term_index     = 3'($urandom_range(0, 7));
        it.data_value     = rand_word(it.cmd == CMD_WRITE);
        return it;
    endfunction

    // directed rows; the typed ones are read straight off the definition
    stim_row_t directed [] = '{
        // after reset every function is 1/1
        '{CMD_EVAL,  1'b0, 1'b0, 3'd0, 32'h0000_0000, 1'b1, '{ONE, 0, 0, ST_OK}},
        '{CMD_EVAL,  1'b1, 1'b0, 3'd0, 32'h7FFF_FFFF, 1'b1, '{ONE, 0, 0, ST_OK}},
        '{CMD_EVAL,  1'b0, 1'b1, 3'd7, 32'h8000_0000, 1'b1, '{ONE, 0, 0, ST_OK}},
        // max numerator over smallest denominator saturates
        '{CMD_WRITE, 1'b0, 1'b0, 3'd0, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_WRITE, 1'b0, 1'b1, 3'd0, 32'h0000_0001, 1'b0, '0},
        '{CMD_EVAL,  1'b0, 1'b0, 3'd0, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 0, 0, ST_SAT}},
        // zero denominator
        '{CMD_WRITE, 1'b0, 1'b1, 3'd0, 32'h0000_0000, 1'b0, '0},
        '{CMD_EVAL,  1'b0, 1'b0, 3'd0, 32'h0000_0005, 1'b1, '{0, 0, 0, ST_DEN0}},
        // top term index, outside the used count
        '{CMD_WRITE, 1'b0, 1'b0, 3'd7, 32'h8000_0000, 1'b0, '0},
        '{CMD_WRITE, 1'b1, 1'b1, 3'd7, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_WRITE, 1'b1, 1'b0, 3'd3, 32'h0002_0000, 1'b0, '0},
        '{CMD_WRITE, 1'b0, 1'b1, 3'd0, ONE,           1'b0, '0},
        '{CMD_EVAL,  1'b0, 1'b0, 3'd0, 32'h0000_8000, 1'b0, '0},
        // most negative over -1.0 overflows
        '{CMD_WRITE, 1'b1, 1'b0, 3'd0, 32'h8000_0000, 1'b0, '0},
        '{CMD_WRITE, 1'b1, 1'b1, 3'd0, 32'hFFFF_0000, 1'b0, '0},
        '{CMD_EVAL,  1'b1, 1'b1, 3'd5, 32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 0, 0, ST_SAT}},
        '{CMD_WRITE, 1'b1, 1'b1, 3'd0, ONE,           1'b0, '0},
        '{CMD_EVAL,  1'b1, 1'b0, 3'd0, 32'h0001_8000, 1'b0, '0}
    };

    // main sequence
    initial
    begin
        logic [3:0] cfg [6][4];
        cfg = '{'{4'd8, 4'd8, 4'd8, 4'd8}, '{4'd0, 4'd0, 4'd0, 4'd0},
                '{4'd15, 4'd15, 4'd15, 4'd15}, '{4'd3, 4'd2, 4'd8, 4'd1},
                '{4'd1, 4'd1, 4'd1, 4'd1}, '{4'd5, 4'd7, 4'd4, 4'd6}};
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_if.valid          = 1'b0;
        in_if.cmd            = CMD_WRITE;
        in_if.which_function = 1'b0;
        in_if.which_part     = 1'b0;
        in_if.term_index     = '0;
        in_if.data_value     = '0;
        fail_count = 0;
        no_idle    = 1'b0;
        long_hold  = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            count_shadow[p] = 4'd1;
            for (int i = 0; i < NTERMS; i++)
                coef_shadow[p][i] = (i == 0) ? ONE : 32'd0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        foreach (directed[k])
        begin
            offer_item(directed[k]);
            sender_gap();
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
                set_counts(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            else
                set_counts(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3]);
            no_idle   = (ph == 4);
            long_hold = (ph == 1);
            for (int n = 0; n < 105; n++)
            begin
                offer_item(rand_item());
                // sender waits for everything in flight once per phase
                if (n == 50)
                    drain();
                else
                    sender_gap();
            end
            drain();
        end

        $display("items: %0d evaluations, %0d coefficient writes, %0d results",
                 eval_count, write_count, result_count);
        $display("zero-denominator results %0d, saturated results %0d, mismatches %0d",
                 den0_count, sat_count, fail_count);
        if (fail_count == 0 && result_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
